>>> design/sliding_window_statistics_defines.svh
// ---------------------------------------------------------------------------
// Sliding window statistics: assertion macros
// Immediate-cycle and next-cycle implication checks on clk, gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sws_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window statistics package
// Window size, datapath widths and the controller/datapath handshake types.
// ---------------------------------------------------------------------------
package sws_pkg;

  localparam int WINDOW = 64;
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SMP_W  = 16;
  localparam int THR_W  = 16;
  localparam int SUM_W  = SMP_W + PTR_W;        // signed running sum
  localparam int SQ_W   = 2 * SMP_W - 1 + PTR_W; // sum of squares
  localparam int NUM_W  = SQ_W + CNT_W;         // n*sumsq - sum^2
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 38;
  localparam int DEV_W  = 24;

  // input word commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic accept;   // take the input word
    logic rd;       // read next ring entry
    logic nsq;      // n * sumsq
    logic ssq;      // sum^2
    logic nx;       // n * newest, threshold^2
    logic num;      // numerator and |n*x - sum|
    logic dsq;      // deviation^2, launch dividers
    logic plo;      // threshold^2 * low half of numerator
    logic phi;      // threshold^2 * high half of numerator
    logic rsum;     // combine partial products
    logic cmp;      // outlier compare
    logic sq_start; // launch square roots
    logic load;     // load result register
  } sws_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic rd_last;
    logic div_done;
    logic sqrt_done;
  } sws_sts_t;

endpackage

>>> design/sws_if.sv
// ---------------------------------------------------------------------------
// Sliding window statistics channels
// Valid/ready channels for input words, result words and the threshold write.
// ---------------------------------------------------------------------------
interface sws_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [15:0] sample;
  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface sws_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] newest;
  logic        [6:0]  count;
  logic signed [23:0] mean;
  logic        [37:0] variance;
  logic        [23:0] deviation;
  logic        [23:0] rms;
  logic signed [15:0] minimum;
  logic signed [15:0] maximum;
  logic               outlier;
  modport source (output valid, output newest, output count, output mean,
                  output variance, output deviation, output rms, output minimum,
                  output maximum, output outlier, input ready);
  modport sink   (input valid, input newest, input count, input mean,
                  input variance, input deviation, input rms, input minimum,
                  input maximum, input outlier, output ready);
endinterface

interface sws_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] z_threshold;
  modport source (output valid, output z_threshold, input ready);
  modport sink   (input valid, input z_threshold, output ready);
endinterface

>>> design/sws_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle, quotient floor'd.
// ---------------------------------------------------------------------------
module sws_div #(
  parameter int DW = 30,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quot,
  output logic          busy
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {rem_r, q_r[DW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = !diff[VW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign quot = q_r;
  assign busy = busy_r;

endmodule

>>> design/sws_sqrt.sv
// ---------------------------------------------------------------------------
// Integer square root
// Two radicand bits per cycle, root floor'd.
// ---------------------------------------------------------------------------
module sws_sqrt #(
  parameter int SW = 60
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SW-1:0]   radicand,
  output logic [SW/2-1:0] root,
  output logic            busy
);

  localparam int NW = SW / 2;
  localparam int RW = NW + 2;
  localparam int CW = $clog2(NW + 1);

  logic [SW-1:0] rad_r;
  logic [NW-1:0] root_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [RW+1:0] shifted;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  assign shifted = {rem_r, rad_r[SW-1:SW-2]};
  assign trial   = (RW + 2)'({root_r, 2'b01});
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SW-3:0], 2'b00};
      root_r <= {root_r[NW-2:0], ge};
      rem_r  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
    end
  end

  assign root = root_r;
  assign busy = busy_r;

endmodule

>>> design/sws_dp.sv
// ---------------------------------------------------------------------------
// Sliding window statistics datapath
// Sample ring, scan accumulators, product chain, dividers, roots, result reg.
// ---------------------------------------------------------------------------
module sws_dp
  import sws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  sws_cmd_t                 cmd,
  output sws_sts_t                 sts,
  input  logic                     in_cmd,
  input  logic signed [SMP_W-1:0]  in_sample,
  input  logic                     cfg_wr,
  input  logic [THR_W-1:0]         cfg_thr,
  output logic signed [SMP_W-1:0]  newest,
  output logic [CNT_W-1:0]         count,
  output logic signed [MEAN_W-1:0] mean,
  output logic [VAR_W-1:0]         variance,
  output logic [DEV_W-1:0]         deviation,
  output logic [DEV_W-1:0]         rms,
  output logic signed [SMP_W-1:0]  minimum,
  output logic signed [SMP_W-1:0]  maximum,
  output logic                     outlier
);

  localparam int NX_W  = CNT_W + 1 + SMP_W;
  localparam int DA_W  = NX_W + 1;
  localparam int HALF  = NUM_W / 2;
  localparam int R_W   = 2 * THR_W + NUM_W;
  localparam int MD_W  = SUM_W + 8;
  localparam int VD_W  = NUM_W + 16;
  localparam int RD_W  = SQ_W + 16;
  localparam int RS_W  = RD_W + (RD_W % 2);

  logic signed [SMP_W-1:0] ring [WINDOW];

  logic [PTR_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [THR_W-1:0]        thr_r;
  logic [PTR_W-1:0]        idx_r;
  logic                    acc_vld_r;
  logic                    first_r;
  logic signed [SMP_W-1:0] rd_data_r;
  logic signed [SMP_W-1:0] x_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sumsq_r;
  logic signed [SMP_W-1:0] mn_r;
  logic signed [SMP_W-1:0] mx_r;
  logic [NUM_W-1:0]        nsq_r;
  logic [NUM_W-1:0]        ssq_r;
  logic signed [NX_W-1:0]  nx_r;
  logic [2*THR_W-1:0]      t2_r;
  logic [NUM_W-1:0]        num_r;
  logic [DA_W-1:0]         dabs_r;
  logic [2*DA_W-1:0]       dsq_r;
  logic [2*THR_W+HALF-1:0] plo_r;
  logic [R_W-HALF-1:0]     phi_r;
  logic [R_W-1:0]          rsum_r;
  logic                    outl_r;

  logic signed [2*SMP_W-1:0] sq_w;
  logic [SUM_W-1:0]          asum;
  logic signed [DA_W-1:0]    diff_w;
  logic [MD_W-1:0]           mean_q;
  logic [VD_W-1:0]           var_q;
  logic [RD_W-1:0]           rms_q;
  logic [VD_W/2-1:0]         dev_root;
  logic [RS_W/2-1:0]         rms_root;
  logic                      mdiv_busy, vdiv_busy, rdiv_busy, dsq_busy, rsq_busy;
  logic [MD_W-1:0]           mean_s;

  // Ring, pointer, fill count and threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
      thr_r <= THR_W'(768);
    end else begin
      if (cfg_wr) begin
        thr_r <= cfg_thr;
      end
      if (cmd.accept) begin
        if (in_cmd) begin
          ptr_r <= '0;
          cnt_r <= '0;
        end else begin
          ptr_r <= (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
          if (cnt_r != CNT_W'(WINDOW)) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_cmd) begin
      ring[ptr_r] <= in_sample;
    end
    if (cmd.rd) begin
      rd_data_r <= ring[idx_r];
    end
  end

  // Scan: read one entry a cycle, accumulate it in the cycle after the read
  assign sq_w = rd_data_r * rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r   <= '0;
      first_r <= 1'b1;
      if (!in_cmd) begin
        x_r <= in_sample;
      end
    end else if (cmd.rd) begin
      idx_r <= idx_r + PTR_W'(1);
    end
    if (acc_vld_r) begin
      first_r <= 1'b0;
      if (first_r) begin
        sum_r   <= SUM_W'(rd_data_r);
        sumsq_r <= SQ_W'(sq_w[2*SMP_W-2:0]);
        mn_r    <= rd_data_r;
        mx_r    <= rd_data_r;
      end else begin
        sum_r   <= sum_r + SUM_W'(rd_data_r);
        sumsq_r <= sumsq_r + SQ_W'(sq_w[2*SMP_W-2:0]);
        if (rd_data_r < mn_r) mn_r <= rd_data_r;
        if (rd_data_r > mx_r) mx_r <= rd_data_r;
      end
    end
  end

  // Product chain, each step enabled by its own command
  assign asum   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign diff_w = DA_W'(nx_r) - DA_W'(sum_r);

  always_ff @(posedge clk) begin
    if (cmd.nsq) begin
      nsq_r <= NUM_W'(cnt_r) * NUM_W'(sumsq_r);
    end
    if (cmd.ssq) begin
      ssq_r <= NUM_W'(asum) * NUM_W'(asum);
    end
    if (cmd.nx) begin
      nx_r <= $signed({1'b0, cnt_r}) * x_r;
      t2_r <= thr_r * thr_r;
    end
    if (cmd.num) begin
      num_r  <= nsq_r - ssq_r;
      dabs_r <= diff_w[DA_W-1] ? DA_W'(-diff_w) : DA_W'(diff_w);
    end
    if (cmd.dsq) begin
      dsq_r <= dabs_r * dabs_r;
    end
    if (cmd.plo) begin
      plo_r <= t2_r * num_r[HALF-1:0];
    end
    if (cmd.phi) begin
      phi_r <= t2_r * num_r[NUM_W-1:HALF];
    end
    if (cmd.rsum) begin
      rsum_r <= R_W'(plo_r) + {phi_r, HALF'(0)};
    end
    if (cmd.cmp) begin
      outl_r <= (cnt_r >= CNT_W'(2)) && (num_r != '0) &&
                (R_W'({dsq_r, 16'h0000}) > rsum_r);
    end
  end

  // Mean, variance and mean-square dividers
  sws_div #(.DW(MD_W), .VW(CNT_W)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.dsq),
    .dividend({asum, 8'h00}), .divisor(cnt_r),
    .quot(mean_q), .busy(mdiv_busy)
  );

  sws_div #(.DW(VD_W), .VW(2 * CNT_W)) u_vdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.dsq),
    .dividend({num_r, 16'h0000}),
    .divisor((2 * CNT_W)'(cnt_r) * (2 * CNT_W)'(cnt_r)),
    .quot(var_q), .busy(vdiv_busy)
  );

  sws_div #(.DW(RD_W), .VW(CNT_W)) u_rdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.dsq),
    .dividend({sumsq_r, 16'h0000}), .divisor(cnt_r),
    .quot(rms_q), .busy(rdiv_busy)
  );

  sws_sqrt #(.SW(VD_W)) u_dsqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sq_start),
    .radicand(var_q), .root(dev_root), .busy(dsq_busy)
  );

  sws_sqrt #(.SW(RS_W)) u_rsqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sq_start),
    .radicand(RS_W'(rms_q)), .root(rms_root), .busy(rsq_busy)
  );

  assign mean_s = sum_r[SUM_W-1] ? MD_W'(-mean_q) : mean_q;

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cnt_r == '0) begin
        newest    <= '0;
        count     <= '0;
        mean      <= '0;
        variance  <= '0;
        deviation <= '0;
        rms       <= '0;
        minimum   <= '0;
        maximum   <= '0;
        outlier   <= 1'b0;
      end else begin
        newest    <= x_r;
        count     <= cnt_r;
        mean      <= mean_s[MEAN_W-1:0];
        variance  <= var_q[8 +: VAR_W];
        deviation <= dev_root[DEV_W-1:0];
        rms       <= rms_root[DEV_W-1:0];
        minimum   <= mn_r;
        maximum   <= mx_r;
        outlier   <= outl_r;
      end
    end
  end

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.rd_last   = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign sts.div_done  = !(mdiv_busy || vdiv_busy || rdiv_busy);
  assign sts.sqrt_done = !(dsq_busy || rsq_busy);

endmodule

>>> design/sws_ctrl.sv
// ---------------------------------------------------------------------------
// Sliding window statistics controller
// Sequences scan, product chain, divides and roots; owns the handshakes.
// ---------------------------------------------------------------------------
module sws_ctrl
  import sws_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sws_sts_t sts,
  output sws_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_SCAN, ST_TAIL, ST_NSQ, ST_SSQ, ST_NX, ST_NUM,
    ST_DSQ, ST_PLO, ST_PHI, ST_RSUM, ST_CMP, ST_DIVW, ST_SQGO, ST_SQW, ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r;
  logic   load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign load      = (state_r == ST_FIN) && (!out_vld_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = sts.cnt_zero ? ST_FIN : ST_SCAN;
      ST_SCAN: if (sts.rd_last) state_nxt = ST_TAIL;
      ST_TAIL: state_nxt = ST_NSQ;
      ST_NSQ:  state_nxt = ST_SSQ;
      ST_SSQ:  state_nxt = ST_NX;
      ST_NX:   state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_DSQ;
      ST_DSQ:  state_nxt = ST_PLO;
      ST_PLO:  state_nxt = ST_PHI;
      ST_PHI:  state_nxt = ST_RSUM;
      ST_RSUM: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_DIVW;
      ST_DIVW: if (sts.div_done) state_nxt = ST_SQGO;
      ST_SQGO: state_nxt = ST_SQW;
      ST_SQW:  if (sts.sqrt_done) state_nxt = ST_FIN;
      ST_FIN:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.rd       = (state_r == ST_SCAN);
    cmd.nsq      = (state_r == ST_NSQ);
    cmd.ssq      = (state_r == ST_SSQ);
    cmd.nx       = (state_r == ST_NX);
    cmd.num      = (state_r == ST_NUM);
    cmd.dsq      = (state_r == ST_DSQ);
    cmd.plo      = (state_r == ST_PLO);
    cmd.phi      = (state_r == ST_PHI);
    cmd.rsum     = (state_r == ST_RSUM);
    cmd.cmp      = (state_r == ST_CMP);
    cmd.sq_start = (state_r == ST_SQGO);
    cmd.load     = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // hold the result word until taken; a new load replaces it
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

>>> design/sliding_window_statistics.sv
// ---------------------------------------------------------------------------
// Sliding window statistics
// Mean, variance, deviation, RMS, min/max and z-score flag over 64 samples.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                            width
//  in_ch    in   cmd, sample                                        1+16
//  out_ch   out  newest count mean variance deviation rms min max   1..38
//                outlier
//  cfg_ch   in   z_threshold (Q8.8)                                 16
//
// A push runs the scan, the product chain, the dividers and the roots; an
// empty window goes from the check straight to the result load. The slowest
// parts are the 60-step variance divide and the 30-step square root after it.
// One word is in flight at a time; in_ch.ready rises once the result sits in
// the output register, so a stalled out_ch holds only the final load.
// Synchronous active-low reset clears pointer and count and sets the threshold to 3.0.
// ---------------------------------------------------------------------------
`include "sliding_window_statistics_defines.svh"

module sliding_window_statistics
  import sws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sws_in_if.sink    in_ch,
  sws_out_if.source out_ch,
  sws_cfg_if.sink   cfg_ch
);

  sws_cmd_t cmd;
  sws_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sws_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_cmd   (in_ch.cmd),
    .in_sample(in_ch.sample),
    .cfg_wr   (cfg_ch.valid),
    .cfg_thr  (cfg_ch.z_threshold),
    .newest   (out_ch.newest),
    .count    (out_ch.count),
    .mean     (out_ch.mean),
    .variance (out_ch.variance),
    .deviation(out_ch.deviation),
    .rms      (out_ch.rms),
    .minimum  (out_ch.minimum),
    .maximum  (out_ch.maximum),
    .outlier  (out_ch.outlier)
  );

  `SWS_ASSERT_NOW(a_cnt_max, out_ch.valid, out_ch.count <= CNT_W'(WINDOW), "count above window")
  `SWS_ASSERT_NOW(a_empty_zero, out_ch.valid && out_ch.count == '0, out_ch.mean == '0 && out_ch.rms == '0 && !out_ch.outlier, "empty window not zero")
  `SWS_ASSERT_NOW(a_outl_two, out_ch.valid && out_ch.outlier, out_ch.count >= CNT_W'(2), "outlier below two samples")
  `SWS_ASSERT_NOW(a_rms_dev, out_ch.valid, out_ch.rms >= out_ch.deviation, "rms below deviation")
  `SWS_ASSERT_NEXT(a_one_word, in_ch.valid && in_ch.ready, !in_ch.ready, "second word taken early")

endmodule
